@@ rtl/uahp_pkg.sv @@
// shared types and constants for the url authority host/port parser
package uahp_pkg;

  // url capacity in bytes and the widths that follow from it
  localparam int unsigned MAX_URL_LEN = 256;
  localparam int unsigned POS_W       = $clog2(MAX_URL_LEN + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_URL_LEN);

  localparam int unsigned ACC_W  = 17;
  localparam int unsigned MUL_W  = ACC_W + 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [ACC_W-1:0] PORT_SAT = 17'd65536;
  localparam logic [ACC_W-1:0] PORT_MAX = 17'd65535;

  localparam logic [15:0] DEFAULT_PORT_RST  = 16'd8123;
  localparam logic [7:0]  MAX_HOST_SIZE_RST = 8'd64;

  // register index, taken from paddr[2]
  localparam logic REG_DEFAULT_PORT  = 1'b0;
  localparam logic REG_MAX_HOST_SIZE = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;

  typedef enum logic [1:0] {
    SCH_NONE,
    SCH_COLON,
    SCH_SLASH
  } scheme_e;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_SIGN,
    PH_DIGITS,
    PH_STOP
  } phase_e;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             ended;
    logic             ovf;
    scheme_e          stage;
    logic             found;
    logic             closed;
    logic [IDX_W-1:0] aend;
    logic [POS_W-1:0] hbeg;
    logic             colon;
    logic [IDX_W-1:0] cidx;
    logic [ACC_W-1:0] acc;
    phase_e           phase;
  } parse_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  host_start;
    logic [7:0]  host_chars;
    logic [15:0] port;
  } res_t;

  typedef struct packed {
    logic [15:0] default_port;
    logic [7:0]  max_host_size;
  } cfg_t;

endpackage

@@ rtl/uahp_cfg.sv @@
// apb register file: default port and host buffer size
module uahp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uahp_pkg::ADDR_W-1:0]   paddr,
  input  logic [uahp_pkg::DATA_W-1:0]   pwdata,
  output logic [uahp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output uahp_pkg::cfg_t                cfg_o
);
  import uahp_pkg::*;

  logic [15:0] default_port_q, default_port_d;
  logic [7:0]  max_host_size_q, max_host_size_d;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    default_port_d  = default_port_q;
    max_host_size_d = max_host_size_q;
    if (wr_en) begin
      case (reg_sel)
        REG_DEFAULT_PORT:  default_port_d  = pwdata[15:0];
        REG_MAX_HOST_SIZE: max_host_size_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q  <= DEFAULT_PORT_RST;
      max_host_size_q <= MAX_HOST_SIZE_RST;
    end else begin
      default_port_q  <= default_port_d;
      max_host_size_q <= max_host_size_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEFAULT_PORT:  prdata = DATA_W'(default_port_q);
      REG_MAX_HOST_SIZE: prdata = DATA_W'(max_host_size_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.default_port  = default_port_q;
  assign cfg_o.max_host_size = max_host_size_q;

endmodule

@@ rtl/uahp_parse.sv @@
// parse state registers, per-byte update and result formation
module uahp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     ch_i,
  input  logic           last_i,
  input  uahp_pkg::cfg_t cfg_i,
  output uahp_pkg::res_t res_o
);
  import uahp_pkg::*;

  parse_t           st_q, st_d, nx;
  logic             is_digit, is_space;
  logic [MUL_W-1:0] acc_mul;
  logic [POS_W-1:0] pos_inc;
  logic [IDX_W-1:0] cur_idx;
  logic [POS_W-1:0] host_end;
  logic [POS_W-1:0] len;

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_space = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
  assign acc_mul  = (MUL_W'(st_q.acc) << 3) + (MUL_W'(st_q.acc) << 1)
                  + MUL_W'(ch_i - CH_ZERO);
  assign pos_inc  = st_q.pos + 1'b1;
  assign cur_idx  = st_q.pos[IDX_W-1:0];

  // next parse state for one byte
  always_comb begin
    nx = st_q;
    if (!st_q.ended && !st_q.ovf) begin
      if (ch_i == CH_NUL) begin
        nx.ended = 1'b1;
      end else if (32'(st_q.pos) >= MAX_URL_LEN) begin
        nx.ovf = 1'b1;
      end else begin
        nx.pos = pos_inc;
        if (!st_q.found && st_q.stage == SCH_SLASH && ch_i == CH_SLASH) begin
          // "://" complete: authority restarts after it
          nx.found  = 1'b1;
          nx.stage  = SCH_NONE;
          nx.closed = 1'b0;
          nx.aend   = '0;
          nx.hbeg   = pos_inc;
          nx.colon  = 1'b0;
          nx.cidx   = '0;
          nx.acc    = '0;
          nx.phase  = PH_WAIT;
        end else begin
          if (!st_q.found) begin
            if (ch_i == CH_COLON) begin
              nx.stage = SCH_COLON;
            end else if (st_q.stage == SCH_COLON && ch_i == CH_SLASH) begin
              nx.stage = SCH_SLASH;
            end else begin
              nx.stage = SCH_NONE;
            end
          end
          if (!st_q.closed) begin
            if (ch_i == CH_SLASH) begin
              nx.closed = 1'b1;
              nx.aend   = cur_idx;
            end else if (ch_i == CH_AT) begin
              nx.hbeg  = pos_inc;
              nx.colon = 1'b0;
              nx.acc   = '0;
              nx.phase = PH_WAIT;
            end else if (ch_i == CH_COLON) begin
              nx.colon = 1'b1;
              nx.cidx  = cur_idx;
              nx.acc   = '0;
              nx.phase = PH_WAIT;
            end else if (st_q.colon && st_q.phase != PH_STOP) begin
              // atoi-style port digits
              if (is_digit) begin
                nx.acc   = (acc_mul > MUL_W'(PORT_SAT)) ? PORT_SAT : acc_mul[ACC_W-1:0];
                nx.phase = PH_DIGITS;
              end else if (st_q.phase == PH_WAIT && is_space) begin
                nx.phase = PH_WAIT;
              end else if (st_q.phase == PH_WAIT && ch_i == CH_PLUS) begin
                nx.phase = PH_SIGN;
              end else begin
                if (st_q.phase != PH_DIGITS) nx.acc = '0;
                nx.phase = PH_STOP;
              end
            end
          end
        end
      end
    end
  end

  // result from the updated state
  always_comb begin
    if (nx.colon) begin
      host_end = POS_W'(nx.cidx);
    end else if (nx.closed) begin
      host_end = POS_W'(nx.aend);
    end else begin
      host_end = nx.pos;
    end
    len = (host_end >= nx.hbeg) ? (host_end - nx.hbeg) : '0;

    res_o.ok = !nx.ovf && (len != '0) && (32'(len) < 32'(cfg_i.max_host_size));
    res_o.host_start = res_o.ok ? 8'(32'(nx.hbeg)) : 8'd0;
    if (!res_o.ok) begin
      res_o.host_chars = 8'd0;
    end else if (32'(len) > 32'd255) begin
      res_o.host_chars = 8'd255;
    end else begin
      res_o.host_chars = 8'(32'(len));
    end
    if (!nx.ovf && nx.colon && (nx.acc != '0) && (nx.acc <= PORT_MAX)) begin
      res_o.port = nx.acc[15:0];
    end else begin
      res_o.port = cfg_i.default_port;
    end
  end

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      st_d = last_i ? '0 : nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

@@ rtl/url_authority_host_port_parser_unit.sv @@
// top level: input register, parser and result register
// Takes one url byte per cycle and emits one result for each byte marked last. An accepted
// byte is held in the input register, where the parse state is updated by a single
// pass of compare and add logic; a last byte then loads the result register, from which
// the result is offered. Throughput is one byte per cycle while input stall is low;
// input stall rises only while a last byte waits for a result register that is still held
// by output stall. Registers may be written over apb only while no url is in progress.
module url_authority_host_port_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uahp_pkg::ADDR_W-1:0]   paddr,
  input  logic [uahp_pkg::DATA_W-1:0]   pwdata,
  output logic [uahp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    ch_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [7:0]                    host_start_o,
  output logic [7:0]                    host_chars_o,
  output logic [15:0]                   port_o
);
  import uahp_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_ch_q;
  logic       s1_last_q;
  logic       s1_fire;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;

  uahp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uahp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .ch_i   (s1_ch_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // a last byte needs a free result register
  assign s1_fire    = s1_valid_q & (~s1_last_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) s1_valid_d = in_valid_i;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_ch_q   <= ch_i;
      s1_last_q <= last_i;
    end
    if (s1_fire && s1_last_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_q.ok;
  assign host_start_o = out_q.host_start;
  assign host_chars_o = out_q.host_chars;
  assign port_o       = out_q.port;

endmodule
